// ===== rtl/wdb_pkg.sv =====
// shared types and constants of the progress stall watchdog bank
// no dependencies; used by every other file of the block except wdb_ram

package wdb_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int MAX_ACTIVE    = 256;
  localparam int CMP_W         = 10;

  localparam int SLOT_W   = 8;
  localparam int TAG_W    = 16;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 32;
  localparam int RATE_W   = 16;
  localparam int THR_W    = LIMIT_W + RATE_W;
  localparam int ENTRY_W  = TAG_W + WORD_W + WORD_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_OBSERVE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED = 2'd2;

  localparam logic REG_STALL_LIMIT = 1'b0;
  localparam logic REG_TICKS       = 1'b1;

  localparam logic [LIMIT_W-1:0] STALL_LIMIT_RESET = 32'd2000;
  localparam logic [RATE_W-1:0]  TICKS_RESET       = 16'd1000;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== rtl/wdb_in_if.sv =====
// request channel into the watchdog bank: valid, ready and the request fields
// depends on wdb_pkg

interface wdb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [wdb_pkg::SLOT_W-1:0]  slot_index;
  logic [wdb_pkg::TAG_W-1:0]   worker_tag;
  logic [wdb_pkg::WORD_W-1:0]  progress;
  logic                        armed;
  logic [wdb_pkg::WORD_W-1:0]  timestamp;

  modport source (
    output valid, opcode, slot_index, worker_tag, progress, armed, timestamp,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot_index, worker_tag, progress, armed, timestamp,
    output ready
  );
endinterface

// ===== rtl/wdb_out_if.sv =====
// result channel out of the watchdog bank: valid, ready and the result fields
// depends on wdb_pkg

interface wdb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fire;
  logic [wdb_pkg::TAG_W-1:0]     alarm_tag;
  logic [wdb_pkg::SLOT_W-1:0]    slot_out;
  logic [wdb_pkg::STATUS_W-1:0]  status;

  modport source (
    output valid, fire, alarm_tag, slot_out, status,
    input  ready
  );
  modport sink (
    input  valid, fire, alarm_tag, slot_out, status,
    output ready
  );
endinterface

// ===== rtl/wdb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module wdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wdb_regs.sv =====
// apb configuration registers and the registered stall threshold
// depends on wdb_pkg

module wdb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wdb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [wdb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [wdb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [wdb_pkg::THR_W-1:0]        threshold
);
  import wdb_pkg::*;

  logic [LIMIT_W-1:0] stall_limit;
  logic [RATE_W-1:0]  ticks;
  logic               wr;
  logic               reg_sel;
  logic [LIMIT_W-1:0] lim_eff;
  logic [RATE_W-1:0]  rate_eff;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit <= STALL_LIMIT_RESET;
      ticks       <= TICKS_RESET;
    end else if (wr) begin
      unique case (reg_sel)
        REG_STALL_LIMIT: stall_limit <= pwdata[LIMIT_W-1:0];
        REG_TICKS:       ticks       <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STALL_LIMIT: prdata = stall_limit;
      REG_TICKS:       prdata = {{(APB_DATA_W-RATE_W){1'b0}}, ticks};
      default:         prdata = '0;
    endcase
  end

  // zero counts as one
  assign lim_eff  = (stall_limit == '0) ? LIMIT_W'(1) : stall_limit;
  assign rate_eff = (ticks == '0) ? RATE_W'(1) : ticks;

  always_ff @(posedge clk) begin
    threshold <= THR_W'(lim_eff) * THR_W'(rate_eff);
  end

endmodule

// ===== rtl/wdb_ctrl.sv =====
// controller: request handshake, two-step sequencing and result valid
// depends on wdb_pkg

module wdb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output wdb_pkg::ctrl_cmd_t cmd
);
  import wdb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_blocked;

  assign out_blocked = out_valid && !out_ready;
  assign in_ready    = (state == S_IDLE);
  assign cmd.load    = in_ready && in_valid;
  assign cmd.commit  = (state == S_EXEC) && !out_blocked;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.commit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/wdb_dpath.sv =====
// datapath: request latch, fill count, slot ram, stall check and result register
// depends on wdb_pkg and wdb_ram

module wdb_dpath #(
  parameter int SLOTS = wdb_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wdb_pkg::ctrl_cmd_t             cmd,
  input  logic                           in_opcode,
  input  logic [wdb_pkg::SLOT_W-1:0]     in_slot_index,
  input  logic [wdb_pkg::TAG_W-1:0]      in_worker_tag,
  input  logic [wdb_pkg::WORD_W-1:0]     in_progress,
  input  logic                           in_armed,
  input  logic [wdb_pkg::WORD_W-1:0]     in_timestamp,
  input  logic [wdb_pkg::THR_W-1:0]      threshold,
  output logic                           fire,
  output logic [wdb_pkg::TAG_W-1:0]      alarm_tag,
  output logic [wdb_pkg::SLOT_W-1:0]     slot_out,
  output logic [wdb_pkg::STATUS_W-1:0]   status
);
  import wdb_pkg::*;

  localparam int ACTIVE = (SLOTS > MAX_ACTIVE) ? MAX_ACTIVE : SLOTS;
  localparam int AW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int CW     = $clog2(ACTIVE + 1);

  logic              op;
  logic [SLOT_W-1:0] idx;
  logic [TAG_W-1:0]  tag;
  logic [WORD_W-1:0] prog;
  logic              armed;
  logic [WORD_W-1:0] ts;
  logic              hit;

  // slots are claimed in order and never released, so used slots form a prefix
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  logic               load_hit;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_entry;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_entry;

  logic [TAG_W-1:0]  rd_tag;
  logic [WORD_W-1:0] rd_seen;
  logic [WORD_W-1:0] rd_start;
  logic [WORD_W-1:0] elapsed;
  logic              same;
  logic              over;
  logic              full;

  logic                fire_next;
  logic [TAG_W-1:0]    alarm_tag_next;
  logic [SLOT_W-1:0]   slot_out_next;
  logic [STATUS_W-1:0] status_next;

  assign load_hit = (CMP_W'(in_slot_index) < CMP_W'(ACTIVE))
                 && (CMP_W'(in_slot_index) < CMP_W'(fill));
  assign rd_en    = cmd.load && (in_opcode == OP_OBSERVE) && load_hit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= in_opcode;
      idx   <= in_slot_index;
      tag   <= in_worker_tag;
      prog  <= in_progress;
      armed <= in_armed;
      ts    <= in_timestamp;
      hit   <= load_hit;
    end
  end

  wdb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ACTIVE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (in_slot_index[AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_tag   = rd_entry[ENTRY_W-1 -: TAG_W];
  assign rd_seen  = rd_entry[2*WORD_W-1 -: WORD_W];
  assign rd_start = rd_entry[WORD_W-1:0];

  assign full    = (fill == CW'(ACTIVE));
  assign same    = armed && (prog == rd_seen);
  assign elapsed = ts - rd_start;
  assign over    = elapsed > WORD_W'(threshold);

  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = idx[AW-1:0];
    wr_entry       = {rd_tag, prog, ts};
    fill_next      = fill;
    fire_next      = 1'b0;
    alarm_tag_next = '0;
    slot_out_next  = '0;
    status_next    = STATUS_OK;
    if (op == OP_REGISTER) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        wr_en          = cmd.commit;
        wr_addr        = fill[AW-1:0];
        wr_entry       = {tag, prog, ts};
        fill_next      = fill + CW'(1);
        alarm_tag_next = tag;
        slot_out_next  = SLOT_W'(fill);
      end
    end else begin
      slot_out_next = idx;
      if (!hit) begin
        status_next = STATUS_UNUSED;
      end else begin
        alarm_tag_next = rd_tag;
        fire_next      = same && over;
        wr_en          = cmd.commit && (!same || over);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.commit) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      fire      <= fire_next;
      alarm_tag <= alarm_tag_next;
      slot_out  <= slot_out_next;
      status    <= status_next;
    end
  end

endmodule

// ===== rtl/progress_stall_watchdog_bank.sv =====
// top level of the progress stall watchdog bank
// depends on wdb_pkg, wdb_in_if, wdb_out_if, wdb_regs, wdb_ctrl, wdb_dpath, wdb_ram
//
// usage
//   in_ch carries one request per valid/ready transfer: opcode register claims
//   the lowest free slot for worker_tag, opcode observe checks slot_index
//   against its stored progress and window start. out_ch returns exactly one
//   result per request: fire, alarm_tag, slot_out and status.
//   each request runs as an accept step, which issues the slot ram read, and an
//   exec step, which does the stall check, the write-back and loads the result
//   register; the registered read ahead of the write-back splits them.
//   a new request is taken only after the previous one has committed its result.
//   the result sits in an output register; a request is still accepted while
//   it waits, and only the write-back step holds until the receiver takes it.
//   reset clears the fill count, so all slots read as free; no clearing pass
//   is needed. stall_limit_us (0x0) and ticks_per_us (0x4) return to 2000 and
//   1000; write them only while no request is in flight.

module progress_stall_watchdog_bank #(
  parameter int SLOTS = wdb_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  wdb_in_if.sink                          in_ch,
  wdb_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wdb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [wdb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [wdb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import wdb_pkg::*;

  ctrl_cmd_t          cmd;
  logic [THR_W-1:0]   threshold;

  wdb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  wdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  wdb_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_opcode     (in_ch.opcode),
    .in_slot_index (in_ch.slot_index),
    .in_worker_tag (in_ch.worker_tag),
    .in_progress   (in_ch.progress),
    .in_armed      (in_ch.armed),
    .in_timestamp  (in_ch.timestamp),
    .threshold     (threshold),
    .fire          (out_ch.fire),
    .alarm_tag     (out_ch.alarm_tag),
    .slot_out      (out_ch.slot_out),
    .status        (out_ch.status)
  );

endmodule
